// ----- rtl/core/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and defaults of the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int DATA_W    = 32;

	typedef logic [2:0] op_code_t;
	localparam op_code_t OP_PUSH_FRONT = 3'd0;
	localparam op_code_t OP_PUSH_BACK  = 3'd1;
	localparam op_code_t OP_POP_FRONT  = 3'd2;
	localparam op_code_t OP_POP_BACK   = 3'd3;
	localparam op_code_t OP_DUMP       = 3'd4;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_UNDERFLOW = 2'd1;
	localparam status_t ST_OVERFLOW  = 2'd2;

	typedef enum logic [1:0] {
		RD_FRONT,
		RD_BACK,
		RD_OFFSET
	} rd_sel_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_ZERO,
		EM_DATA_LAST,
		EM_DATA_DUMP
	} emit_t;

	typedef struct packed {
		logic    wr_front;
		logic    wr_back;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    pop_front;
		logic    pop_back;
		logic    off_load;
		logic    off_inc;
		emit_t   emit;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic dump_end;
	} stat_t;

endpackage

// ----- rtl/core/double_ended_queue_core.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed words kept in a ring store.
//
//   channel   signals                              direction
//   command   start, busy, operation, value        in (busy out)
//   result    done, result_value, status, last     out, one-cycle strobe
//
// push: busy stays low, result in the next cycle
// pop: busy while the ring is read, the read data then pass the result register
// dump of n elements: busy while dumping, one beat per cycle from the front
//   element on, each read through the RAM and result registers, last on the back element
// unused operation codes give no beat; reset empties the queue at once
// the receiver cannot stall, every beat is shown for exactly one cycle
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  deq_pkg::op_code_t                 operation,
	input  logic signed [deq_pkg::DATA_W-1:0] value,
	output logic                              done,
	output logic signed [deq_pkg::DATA_W-1:0] result_value,
	output deq_pkg::status_t                  status,
	output logic                              last
);
	import deq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	deq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (value),
		.stat        (stat),
		.done        (done),
		.result_value(result_value),
		.status      (status),
		.last        (last)
	);

endmodule

// ----- rtl/core/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/deq_datapath.sv -----
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store, front pointer, element count, dump offset and result register.
// ----------------------------------------------------------------------------
module deq_datapath #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  deq_pkg::cmd_t                       cmd,
	input  logic signed [deq_pkg::DATA_W-1:0]   value,
	output deq_pkg::stat_t                      stat,
	output logic                                done,
	output logic signed [deq_pkg::DATA_W-1:0]   result_value,
	output deq_pkg::status_t                    status,
	output logic                                last
);
	import deq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW:0]   DEPTH_X = (PW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [PW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     off_q;
	logic              done_q;
	logic [DATA_W-1:0] result_value_q;
	status_t           status_q;
	logic              last_q;

	logic [PW-1:0]     front_dec;
	logic [PW-1:0]     front_inc;
	logic [PW-1:0]     addr_back;
	logic [PW-1:0]     addr_last;
	logic [PW-1:0]     addr_off;
	logic [PW:0]       front_x;
	logic [PW:0]       cnt_x;
	logic              wr_en;
	logic [PW-1:0]     wr_addr;
	logic [PW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	function automatic logic [PW-1:0] wrap(input logic [PW:0] s);
		return (s >= DEPTH_X) ? PW'(s - DEPTH_X) : PW'(s);
	endfunction

	assign front_x   = {1'b0, front_q};
	assign cnt_x     = (PW + 1)'(count_q);
	assign front_dec = (front_q == '0) ? PW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = wrap(front_x + 1'b1);
	assign addr_back = wrap(front_x + cnt_x);
	assign addr_last = wrap(front_x + cnt_x - 1'b1);
	assign addr_off  = wrap(front_x + (PW + 1)'(off_q));

	assign wr_en   = cmd.wr_front | cmd.wr_back;
	assign wr_addr = cmd.wr_front ? front_dec : addr_back;

	always_comb begin
		case (cmd.rd_sel)
			RD_FRONT:  rd_addr = front_q;
			RD_BACK:   rd_addr = addr_last;
			RD_OFFSET: rd_addr = addr_off;
			default:   rd_addr = front_q;
		endcase
	end

	deq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(value),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q >= DEPTH_C);
	assign stat.dump_end = (off_q == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			off_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cmd.wr_front) begin
				front_q <= front_dec;
				count_q <= count_q + 1'b1;
			end else if (cmd.wr_back) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop_front) begin
				front_q <= front_inc;
				count_q <= count_q - 1'b1;
			end else if (cmd.pop_back) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.off_load) begin
				off_q <= CW'(1);
			end else if (cmd.off_inc) begin
				off_q <= off_q + 1'b1;
			end
			done_q <= (cmd.emit != EM_NONE);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.emit)
			EM_ZERO: begin
				result_value_q <= '0;
				status_q       <= cmd.code;
				last_q         <= 1'b1;
			end
			EM_DATA_LAST: begin
				result_value_q <= rd_data;
				status_q       <= ST_OK;
				last_q         <= 1'b1;
			end
			EM_DATA_DUMP: begin
				result_value_q <= rd_data;
				status_q       <= ST_OK;
				last_q         <= stat.dump_end;
			end
			default: begin
			end
		endcase
	end

	assign done         = done_q;
	assign result_value = result_value_q;
	assign status       = status_q;
	assign last         = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("element count above depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> count_q < DEPTH_C)
		else $error("write into a full ring");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_front || cmd.pop_back) |-> count_q != '0)
		else $error("pop from an empty ring");

	a_dump_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.rd_sel == RD_OFFSET) |-> off_q < count_q)
		else $error("dump read past the back element");

endmodule

// ----- rtl/core/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Operation decode and sequencing of pops and dumps over the ring store.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  deq_pkg::op_code_t operation,
	input  deq_pkg::stat_t    stat,
	output deq_pkg::cmd_t     cmd,
	output logic              busy
);
	import deq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_FRONT,
		S_POP_BACK,
		S_DUMP
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   busy_q;

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RD_FRONT;
		cmd.emit = EM_NONE;
		cmd.code = ST_OK;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (operation)
						OP_PUSH_FRONT: begin
							cmd.emit = EM_ZERO;
							if (stat.full) begin
								cmd.code = ST_OVERFLOW;
							end else begin
								cmd.wr_front = 1'b1;
							end
						end
						OP_PUSH_BACK: begin
							cmd.emit = EM_ZERO;
							if (stat.full) begin
								cmd.code = ST_OVERFLOW;
							end else begin
								cmd.wr_back = 1'b1;
							end
						end
						OP_POP_FRONT: begin
							if (stat.empty) begin
								cmd.emit = EM_ZERO;
								cmd.code = ST_UNDERFLOW;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_FRONT;
								state_nx   = S_POP_FRONT;
							end
						end
						OP_POP_BACK: begin
							if (stat.empty) begin
								cmd.emit = EM_ZERO;
								cmd.code = ST_UNDERFLOW;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_BACK;
								state_nx   = S_POP_BACK;
							end
						end
						OP_DUMP: begin
							if (stat.empty) begin
								cmd.emit = EM_ZERO;
								cmd.code = ST_UNDERFLOW;
							end else begin
								cmd.rd_en    = 1'b1;
								cmd.rd_sel   = RD_FRONT;
								cmd.off_load = 1'b1;
								state_nx     = S_DUMP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_POP_FRONT: begin
				cmd.emit      = EM_DATA_LAST;
				cmd.pop_front = 1'b1;
				state_nx      = S_IDLE;
			end
			S_POP_BACK: begin
				cmd.emit     = EM_DATA_LAST;
				cmd.pop_back = 1'b1;
				state_nx     = S_IDLE;
			end
			S_DUMP: begin
				cmd.emit = EM_DATA_DUMP;
				if (stat.dump_end) begin
					state_nx = S_IDLE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_OFFSET;
					cmd.off_inc = 1'b1;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			busy_q  <= (state_nx != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule
